>>> hdl/rspd_pkg.sv
// Shared types and constants for the RLE sprite palette decoder.
// Used by the top level and by the port checker; depends on nothing.
package rspd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // stream field widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int KIND_W      = 2;
  localparam int COL_W       = 11;
  localparam int CNT_W       = 7;
  localparam int CLR_W       = 8;

  // output tdata bit positions
  localparam int COL_LSB   = 0;
  localparam int ROW_LSB   = COL_LSB + COL_W;
  localparam int CNT_LSB   = ROW_LSB + COL_W;
  localparam int RED_LSB   = CNT_LSB + CNT_W;
  localparam int GREEN_LSB = RED_LSB + CLR_W;
  localparam int BLUE_LSB  = GREEN_LSB + CLR_W;

  // signed line position: start offset difference plus a full line advance
  localparam int POS_W = 18;

  localparam logic [KIND_W-1:0] KIND_SPAN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIZE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd3;

  typedef enum logic [5:0] {
    PH_IMG   = 6'b000001,
    PH_LINE  = 6'b000010,
    PH_RAW   = 6'b000100,
    PH_BLOCK = 6'b001000,
    PH_RUN   = 6'b010000,
    PH_LIT   = 6'b100000
  } phase_t;

endpackage

>>> hdl/rle_sprite_palette_decoder.sv
// Top level of the RLE sprite palette decoder: byte parser, palette RAM and
// output register. Depends on rspd_pkg.
//
// Usage:
//   Input stream: in_tuser = 0 writes one palette entry (index, RGB) and gives
//   no result; in_tuser = 1 delivers one byte of the encoded sprite, in_tlast
//   marking the final byte. Bytes are parsed as an 8-byte image header, then
//   line headers and raw or run-length pixel data.
//   Output stream: at most one item per input item: image size, pixel span
//   (mirrored column, row, count, palette color), dropped off-image span, or
//   stream done. out_tlast is set on the item caused by the final byte.
//   Latency: each result is registered and is on the output in the cycle after
//   its byte is taken. Throughput: one item per cycle while the output is not
//   stalled, set by the parser state loop and the single-port palette RAM (one write or one read per item).
//   Reset: the parser returns to the image header phase; palette contents are
//   undefined until loaded. After the final byte the parser also restarts,
//   keeping the palette.
//   Stall: the output register holds its item while out_tready is low, and
//   in_tready drops only when that register is full and not being drained.
module rle_sprite_palette_decoder #(
  parameter int MAX_WIDTH  = rspd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rspd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rspd_pkg::IN_TDATA_W-1:0]  in_tdata,   // pal_index, pal_rgb, data_byte
  input  logic                             in_tuser,   // op
  input  logic                             in_tlast,   // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rspd_pkg::OUT_TDATA_W-1:0] out_tdata,  // col, row, count, red, green, blue, pad
  output logic [rspd_pkg::KIND_W-1:0]      out_tuser,  // kind
  output logic                             out_tlast   // end_res
);
  import rspd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // input fields
  logic        accept;
  logic [7:0]  pal_index;
  logic [23:0] pal_rgb;
  logic [7:0]  dbyte;

  assign accept    = in_tvalid && in_tready;
  assign pal_index = in_tdata[7:0];
  assign pal_rgb   = in_tdata[31:8];
  assign dbyte     = in_tdata[39:32];

  // parser state
  phase_t                    phase_r, phase_nxt;
  logic [2:0]                hc_r, hc_nxt;
  logic [7:0]                asm_r, asm_nxt;
  logic signed [15:0]        origin_x_r, origin_x_nxt;
  logic signed [15:0]        origin_y_r, origin_y_nxt;
  logic [WW-1:0]             img_w_r, img_w_nxt;
  logic [HW-1:0]             img_h_r, img_h_nxt;
  logic signed [POS_W-1:0]   line_row_r, line_row_nxt;
  logic signed [POS_W-1:0]   line_col_r, line_col_nxt;
  logic                      rle_r, rle_nxt;
  logic [14:0]               line_left_r, line_left_nxt;
  logic [6:0]                block_left_r, block_left_nxt;

  // palette RAM
  logic [23:0] pal_mem [256];
  logic [23:0] rd_r;

  // output register
  logic               s1_vld_r;
  logic [KIND_W-1:0]  s1_kind_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [COL_W-1:0]   s1_row_r;
  logic [CNT_W-1:0]   s1_cnt_r;
  logic               s1_last_r;

  // parser result
  logic               res_vld;
  logic [KIND_W-1:0]  res_kind;
  logic [COL_W-1:0]   res_col;
  logic [COL_W-1:0]   res_row;
  logic [CNT_W-1:0]   res_cnt;
  logic               span_en;
  logic [CNT_W-1:0]   span_cnt;

  logic signed [15:0]      hdr_s;
  logic [15:0]             hdr_word;
  logic signed [POS_W-1:0] size_x;
  logic signed [POS_W-1:0] size_y;
  logic signed [POS_W:0]   x_end;
  logic signed [POS_W:0]   flip_col;
  logic                    span_in;
  logic [6:0]              bsize;

  assign hdr_word = {dbyte, asm_r};
  assign hdr_s    = hdr_word;
  assign size_x   = POS_W'(hdr_s) + POS_W'(1) - POS_W'(origin_x_r);
  assign size_y   = POS_W'(hdr_s) + POS_W'(1) - POS_W'(origin_y_r);
  assign bsize    = dbyte[7:1];
  assign x_end    = (POS_W + 1)'(line_col_r) + $signed((POS_W + 1)'(span_cnt));
  assign flip_col = $signed((POS_W + 1)'(img_w_r)) - (POS_W + 1)'(1)
                    - (POS_W + 1)'(line_col_r);
  assign span_in  = (line_row_r >= 0) && (line_row_r < $signed(POS_W'(img_h_r)))
                    && (line_col_r >= 0) && (x_end <= $signed((POS_W + 1)'(img_w_r)));

  always_comb begin
    phase_nxt      = phase_r;
    hc_nxt         = hc_r;
    asm_nxt        = asm_r;
    origin_x_nxt   = origin_x_r;
    origin_y_nxt   = origin_y_r;
    img_w_nxt      = img_w_r;
    img_h_nxt      = img_h_r;
    line_row_nxt   = line_row_r;
    line_col_nxt   = line_col_r;
    rle_nxt        = rle_r;
    line_left_nxt  = line_left_r;
    block_left_nxt = block_left_r;
    res_vld        = 1'b0;
    res_kind       = KIND_SPAN;
    res_col        = '0;
    res_row        = '0;
    res_cnt        = '0;
    span_en        = 1'b0;
    span_cnt       = CNT_W'(1);

    unique case (phase_r)
      PH_IMG: begin
        case (hc_r)
          3'd1: origin_x_nxt = hdr_s;
          3'd3: origin_y_nxt = hdr_s;
          3'd5: begin
            if (size_x < 0) img_w_nxt = '0;
            else if (size_x > $signed(POS_W'(MAX_WIDTH))) img_w_nxt = WW'(MAX_WIDTH);
            else img_w_nxt = WW'(size_x);
          end
          3'd7: begin
            if (size_y < 0) img_h_nxt = '0;
            else if (size_y > $signed(POS_W'(MAX_HEIGHT))) img_h_nxt = HW'(MAX_HEIGHT);
            else img_h_nxt = HW'(size_y);
            res_vld  = 1'b1;
            res_kind = KIND_SIZE;
            res_col  = COL_W'(img_w_r);
            res_row  = COL_W'(img_h_nxt);
          end
          default: asm_nxt = dbyte;
        endcase
        if (hc_r == 3'd7) begin
          hc_nxt    = '0;
          phase_nxt = PH_LINE;
        end else begin
          hc_nxt = hc_r + 3'd1;
        end
      end
      PH_LINE: begin
        case (hc_r)
          3'd1: begin
            line_left_nxt = hdr_word[15:1];
            rle_nxt       = hdr_word[0];
          end
          3'd3: line_col_nxt = POS_W'(hdr_s) - POS_W'(origin_x_r);
          3'd5: line_row_nxt = POS_W'(hdr_s) - POS_W'(origin_y_r);
          default: asm_nxt = dbyte;
        endcase
        if (hc_r >= 3'd5) begin
          hc_nxt = '0;
          // an empty line goes straight to the next line header
          if (line_left_r == '0) phase_nxt = PH_LINE;
          else phase_nxt = rle_r ? PH_BLOCK : PH_RAW;
        end else begin
          hc_nxt = hc_r + 3'd1;
        end
      end
      PH_RAW: begin
        span_en       = 1'b1;
        line_left_nxt = line_left_r - 15'd1;
        if (line_left_r == 15'd1) phase_nxt = PH_LINE;
      end
      PH_BLOCK: begin
        // a block past the end of the line is taken whole, then the line ends
        if (15'(bsize) >= line_left_r) line_left_nxt = '0;
        else line_left_nxt = line_left_r - 15'(bsize);
        block_left_nxt = bsize;
        if (dbyte[0]) phase_nxt = PH_RUN;
        else if (bsize != '0) phase_nxt = PH_LIT;
      end
      PH_RUN: begin
        if (block_left_r != '0) begin
          span_en  = 1'b1;
          span_cnt = block_left_r;
        end
        block_left_nxt = '0;
        phase_nxt      = (line_left_r != '0) ? PH_BLOCK : PH_LINE;
      end
      PH_LIT: begin
        span_en        = 1'b1;
        block_left_nxt = block_left_r - 7'd1;
        if (block_left_r == 7'd1) phase_nxt = (line_left_r != '0) ? PH_BLOCK : PH_LINE;
      end
      default: phase_nxt = PH_IMG;
    endcase

    if (span_en) begin
      res_vld      = 1'b1;
      res_cnt      = span_cnt;
      line_col_nxt = line_col_r + POS_W'(span_cnt);
      if (span_in) begin
        res_kind = KIND_SPAN;
        res_col  = flip_col[COL_W-1:0];
        res_row  = line_row_r[COL_W-1:0];
      end else begin
        res_kind = KIND_OFF;
      end
    end

    if (in_tlast) begin
      if (!res_vld) begin
        res_vld  = 1'b1;
        res_kind = KIND_DONE;
      end
      phase_nxt      = PH_IMG;
      hc_nxt         = '0;
      asm_nxt        = '0;
      origin_x_nxt   = '0;
      origin_y_nxt   = '0;
      img_w_nxt      = '0;
      img_h_nxt      = '0;
      line_row_nxt   = '0;
      line_col_nxt   = '0;
      rle_nxt        = 1'b0;
      line_left_nxt  = '0;
      block_left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IMG;
      hc_r         <= '0;
      asm_r        <= '0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      img_w_r      <= '0;
      img_h_r      <= '0;
      line_row_r   <= '0;
      line_col_r   <= '0;
      rle_r        <= 1'b0;
      line_left_r  <= '0;
      block_left_r <= '0;
    end else if (accept && in_tuser) begin
      phase_r      <= phase_nxt;
      hc_r         <= hc_nxt;
      asm_r        <= asm_nxt;
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      img_w_r      <= img_w_nxt;
      img_h_r      <= img_h_nxt;
      line_row_r   <= line_row_nxt;
      line_col_r   <= line_col_nxt;
      rle_r        <= rle_nxt;
      line_left_r  <= line_left_nxt;
      block_left_r <= block_left_nxt;
    end
  end

  // Palette RAM: one access per item. A load is seen by the next item's read,
  // so no bypass is needed. Read data is held while the output stalls.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_tuser) pal_mem[pal_index] <= pal_rgb;
      else rd_r <= pal_mem[dbyte];
    end
  end

  assign in_tready = !s1_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= in_tuser && res_vld;
    end else if (out_tready) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= res_kind;
      s1_col_r  <= res_col;
      s1_row_r  <= res_row;
      s1_cnt_r  <= res_cnt;
      s1_last_r <= in_tlast;
    end
  end

  logic        no_color;
  logic [23:0] out_rgb;

  assign no_color   = (s1_kind_r == KIND_SIZE) || (s1_kind_r == KIND_DONE);
  assign out_rgb    = no_color ? 24'd0 : rd_r;
  assign out_tvalid = s1_vld_r;
  assign out_tuser  = s1_kind_r;
  assign out_tlast  = s1_last_r;
  assign out_tdata  = {3'b000, out_rgb[7:0], out_rgb[15:8], out_rgb[23:16],
                       s1_cnt_r, s1_row_r, s1_col_r};

endmodule

>>> hdl/rspd_checker.sv
// Port-level checks for the RLE sprite palette decoder, bound to its top
// level. Depends on rspd_pkg.
module rspd_port_asserts (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rspd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rspd_pkg::KIND_W-1:0]      out_tuser,
  input logic                             out_tlast
);
  import rspd_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [23:0]      rgb;

  assign cnt = out_tdata[CNT_LSB +: CNT_W];
  assign rgb = out_tdata[RED_LSB +: 24];

  // a stalled output item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // the final stream byte always yields an end item on the next cycle
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && in_tlast |=> out_tvalid && out_tlast)
    else $error("final byte did not produce an end item");

  // a done item only comes with the end flag and carries no count or color
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DONE |-> out_tlast && cnt == '0 && rgb == '0)
    else $error("malformed done item");

  // size items carry no count or color; spans are never empty
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SIZE |-> cnt == '0 && rgb == '0)
    else $error("size item carries span payload");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SPAN || out_tuser == KIND_OFF) |-> cnt != '0)
    else $error("empty span item");

endmodule

bind rle_sprite_palette_decoder rspd_port_asserts u_rspd_port_asserts (.*);
